FILE: src/tcp_pkg.sv
package tcp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SIZE_W     = 16;
    localparam int SCR_W      = 16;
    localparam int OUT_W      = 6 * SCR_W;
    localparam int QUO_W      = 16;

    // pipeline depths of the sub-units
    localparam int CULL_LAT = 5;
    localparam int VIEW_LAT = 2;
    localparam int SCR_LAT  = QUO_W + 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_X = 3'd0,
        REG_VIEW_Y = 3'd1,
        REG_VIEW_Z = 3'd2,
        REG_CAMERA = 3'd3,
        REG_SCALE  = 3'd4,
        REG_SCREEN = 3'd5
    } cfg_reg_t;

endpackage

FILE: src/tcp_cull.sv
module tcp_cull
    import tcp_pkg::*;
#(
    parameter int COORD_BITS = 16
)(
    input  logic                        clk,
    input  logic                        en,
    input  logic [8:0][COORD_BITS-1:0]  tri_in,
    input  logic [2:0][COORD_BITS-1:0]  cam,
    output logic                        front
);

    localparam int E_W   = COORD_BITS + 1;
    localparam int P_W   = 2 * E_W;
    localparam int N_W   = P_W + 1;
    localparam int T_W   = N_W + E_W;
    localparam int DOT_W = T_W + 2;

    logic signed [E_W-1:0]   e1_reg [3];
    logic signed [E_W-1:0]   e2_reg [3];
    logic signed [E_W-1:0]   d1_reg [3];
    logic signed [E_W-1:0]   d2_reg [3];
    logic signed [E_W-1:0]   d3_reg [3];
    logic signed [P_W-1:0]   p_reg  [6];
    logic signed [N_W-1:0]   n_reg  [3];
    logic signed [T_W-1:0]   t_reg  [3];
    logic signed [DOT_W-1:0] dot;
    logic                    front_reg;

    assign dot = DOT_W'(t_reg[0]) + DOT_W'(t_reg[1]) + DOT_W'(t_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e1_reg[j] <= E_W'($signed(tri_in[3 + j])) - E_W'($signed(tri_in[j]));
                e2_reg[j] <= E_W'($signed(tri_in[6 + j])) - E_W'($signed(tri_in[j]));
                d1_reg[j] <= E_W'($signed(tri_in[j])) - E_W'($signed(cam[j]));
                d2_reg[j] <= d1_reg[j];
                d3_reg[j] <= d2_reg[j];
            end
            // cross product terms
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int j = 0; j < 3; j++)
            begin
                n_reg[j] <= N_W'(p_reg[2 * j]) - N_W'(p_reg[2 * j + 1]);
                t_reg[j] <= n_reg[j] * d3_reg[j];
            end
            front_reg <= dot[DOT_W-1];
        end
    end

    assign front = front_reg;

endmodule

FILE: src/tcp_view.sv
module tcp_view
    import tcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 12,
    localparam int VIEW_W    = 2 * COORD_BITS + 2 - FRAC_BITS
)(
    input  logic                          clk,
    input  logic                          en,
    input  logic [2:0][4*COORD_BITS-1:0]  rows,
    input  logic [2:0][COORD_BITS-1:0]    point,
    output logic [2:0][VIEW_W-1:0]        view
);

    localparam int PR_W  = 2 * COORD_BITS;
    localparam int ACC_W = PR_W + 2;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        logic signed [PR_W-1:0]       prod_reg [3];
        logic signed [COORD_BITS-1:0] t_reg;
        logic signed [ACC_W-1:0]      acc;
        logic [VIEW_W-1:0]            view_reg;

        assign acc = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2])
                   + (ACC_W'(t_reg) <<< FRAC_BITS);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[j] <= $signed(rows[r][j*COORD_BITS +: COORD_BITS])
                                 * $signed(point[j]);
                end
                t_reg    <= $signed(rows[r][3*COORD_BITS +: COORD_BITS]);
                // dropping the low bits floors toward minus infinity
                view_reg <= acc[ACC_W-1:FRAC_BITS];
            end
        end

        assign view[r] = view_reg;
    end

endmodule

FILE: src/tcp_screen.sv
module tcp_screen
    import tcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 12,
    localparam int VIEW_W    = 2 * COORD_BITS + 2 - FRAC_BITS
)(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] scale,
    input  logic signed [VIEW_W-1:0]     v,
    input  logic signed [VIEW_W-1:0]     w,
    input  logic [SIZE_W-1:0]            size,
    output logic [SCR_W-1:0]             result
);

    localparam int W_W   = (VIEW_W > FRAC_BITS + 1) ? VIEW_W : FRAC_BITS + 2;
    localparam int SV_W  = COORD_BITS + VIEW_W;
    localparam int WF_W  = W_W + FRAC_BITS;
    localparam int A_W   = ((SV_W > WF_W) ? SV_W : WF_W) + 1;
    localparam int LO_W  = A_W / 2;
    localparam int HI_W  = A_W - LO_W;
    localparam int SZ_W  = SIZE_W + 1;
    localparam int LP_W  = LO_W + 1 + SZ_W;
    localparam int HP_W  = HI_W + SZ_W;
    localparam int NUM_W = A_W + SZ_W + 1;
    localparam int N_W   = NUM_W - FRAC_BITS - 1;
    localparam int REM_W = W_W + QUO_W;
    localparam int CMP_W = ((N_W > REM_W) ? N_W : REM_W) + 1;

    localparam logic [SCR_W-1:0] SAT_POS = {1'b0, {(SCR_W-1){1'b1}}};
    localparam logic [SCR_W-1:0] SAT_NEG = {1'b1, {(SCR_W-1){1'b0}}};

    logic signed [SV_W-1:0]  sv1_reg;
    logic signed [W_W-1:0]   w1_reg, w2_reg, w3_reg, w4_reg;
    logic [SIZE_W-1:0]       size1_reg, size2_reg;
    logic signed [A_W-1:0]   a2_reg;
    logic signed [LP_W-1:0]  lo3_reg;
    logic signed [HP_W-1:0]  hi3_reg;
    logic signed [NUM_W-1:0] num4_reg;
    logic [N_W-1:0]          n5_reg;
    logic [W_W-1:0]          d5_reg;
    logic                    neg5_reg;
    logic signed [W_W-1:0]   w_sel;
    logic [NUM_W-1:0]        num_mag;
    logic [CMP_W-1:0]        n_ext;
    logic [REM_W-1:0]        rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]        q_reg    [QUO_W+1];
    logic [W_W-1:0]          dd_reg   [QUO_W+1];
    logic                    neg_reg  [QUO_W+1];
    logic                    sat_reg  [QUO_W+1];
    logic [SCR_W-1:0]        result_next;
    logic [SCR_W-1:0]        result_reg;

    // zero w means no divide, the same as dividing by w equal to one
    assign w_sel   = (w == '0) ? (W_W'(1) <<< FRAC_BITS) : W_W'(w);
    assign num_mag = num4_reg[NUM_W-1] ? (~num4_reg + 1'b1) : num4_reg;
    assign n_ext   = CMP_W'(n5_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv1_reg   <= scale * v;
            w1_reg    <= w_sel;
            size1_reg <= size;

            a2_reg    <= A_W'(sv1_reg) + (A_W'(w1_reg) <<< FRAC_BITS);
            w2_reg    <= w1_reg;
            size2_reg <= size1_reg;

            // product split in two halves
            lo3_reg   <= $signed({1'b0, a2_reg[LO_W-1:0]}) * $signed({1'b0, size2_reg});
            hi3_reg   <= $signed(a2_reg[A_W-1:LO_W]) * $signed({1'b0, size2_reg});
            w3_reg    <= w2_reg;

            num4_reg  <= (NUM_W'(hi3_reg) <<< LO_W) + NUM_W'(lo3_reg)
                       - (NUM_W'(w3_reg) <<< (FRAC_BITS + 1));
            w4_reg    <= w3_reg;

            n5_reg    <= num_mag[NUM_W-1:FRAC_BITS+1];
            d5_reg    <= w4_reg[W_W-1] ? W_W'(-w4_reg) : W_W'(w4_reg);
            neg5_reg  <= num4_reg[NUM_W-1] ^ w4_reg[W_W-1];

            rem_reg[0] <= n_ext[REM_W-1:0];
            q_reg[0]   <= '0;
            dd_reg[0]  <= d5_reg;
            neg_reg[0] <= neg5_reg;
            sat_reg[0] <= n_ext >= (CMP_W'(d5_reg) << QUO_W);

            result_reg <= result_next;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        logic [REM_W:0] trial;

        assign trial = {1'b0, rem_reg[k]} - ((REM_W + 1)'(dd_reg[k]) << (QUO_W - 1 - k));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= trial[REM_W] ? rem_reg[k] : trial[REM_W-1:0];
                q_reg[k+1]   <= trial[REM_W] ? q_reg[k]
                              : (q_reg[k] | (QUO_W'(1) << (QUO_W - 1 - k)));
                dd_reg[k+1]  <= dd_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    always_comb
    begin
        if (neg_reg[QUO_W])
        begin
            if (sat_reg[QUO_W] || q_reg[QUO_W] > QUO_W'(SAT_NEG))
                result_next = SAT_NEG;
            else
                result_next = SCR_W'(-q_reg[QUO_W]);
        end
        else
        begin
            if (sat_reg[QUO_W] || q_reg[QUO_W] > QUO_W'(SAT_POS))
                result_next = SAT_POS;
            else
                result_next = SCR_W'(q_reg[QUO_W]);
        end
    end

    assign result = result_reg;

endmodule

FILE: src/triangle_cull_and_project_unit.sv
// triangle cull and perspective projection unit
//
// s_axis carries one world-space triangle per beat, nine signed coordinates.
// m_axis carries one result per triangle: tuser is the visible flag and
// tdata the six screen coordinates, all zero when the triangle is culled.
// cfg writes the view matrix rows, camera position, projection scale and
// screen size; cfg_ready is always high and writes take effect at once.
//
// with default parameters an accepted input beat passes through 2 view
// transform stages, 23 screen stages (16 of them a one-bit-per-stage
// restoring divider) and the output register to m_axis. throughput is one
// triangle per cycle unless m_axis stalls; six dividers run side by side.
//
// reset clears the configuration registers and all valid bits; the unit
// takes a beat as soon as reset is released. when m_axis stalls the whole
// pipeline holds and s_axis_tready drops until the output beat is taken.
module triangle_cull_and_project_unit
    import tcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 12,
    localparam int IN_W      = ((9 * COORD_BITS + 7) / 8) * 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // screen_ax ay bx by cx cy
    output logic [0:0]            m_axis_tuser,  // visible
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int VIEW_W   = 2 * COORD_BITS + 2 - FRAC_BITS;
    localparam int ROW_W    = 4 * COORD_BITS;
    localparam int CAM_W    = 3 * COORD_BITS;
    localparam int PSC_W    = 2 * COORD_BITS;
    localparam int PIPE_LAT = VIEW_LAT + SCR_LAT;
    localparam int DLY      = PIPE_LAT - CULL_LAT;

    logic [CFG_DATA_W-1:0] view_row_x_reg, view_row_y_reg, view_row_z_reg;
    logic [47:0]           camera_position_reg;
    logic [31:0]           projection_scale_reg;
    logic [31:0]           screen_size_reg;

    logic [ROW_W+CFG_DATA_W-1:0] row_x_ext, row_y_ext, row_z_ext;
    logic [CAM_W+47:0]           cam_ext;
    logic [PSC_W+31:0]           psc_ext;
    logic [2:0][ROW_W-1:0]       rows;
    logic [2:0][COORD_BITS-1:0]  cam;
    logic [1:0][COORD_BITS-1:0]  psc;
    logic [8:0][COORD_BITS-1:0]  tri_in;
    logic [2:0][2:0][VIEW_W-1:0] view;
    logic [5:0][SCR_W-1:0]       scr;

    logic                  adv;
    logic                  front;
    logic [PIPE_LAT-1:0]   vld_reg;
    logic [DLY-1:0]        vis_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;
    logic                  out_vis_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_row_x_reg       <= '0;
            view_row_y_reg       <= '0;
            view_row_z_reg       <= '0;
            camera_position_reg  <= '0;
            projection_scale_reg <= '0;
            screen_size_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VIEW_X: view_row_x_reg       <= cfg_data;
                REG_VIEW_Y: view_row_y_reg       <= cfg_data;
                REG_VIEW_Z: view_row_z_reg       <= cfg_data;
                REG_CAMERA: camera_position_reg  <= cfg_data[47:0];
                REG_SCALE:  projection_scale_reg <= cfg_data[31:0];
                REG_SCREEN: screen_size_reg      <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // entries past the end of a register read as zero
    assign row_x_ext = {{ROW_W{1'b0}}, view_row_x_reg};
    assign row_y_ext = {{ROW_W{1'b0}}, view_row_y_reg};
    assign row_z_ext = {{ROW_W{1'b0}}, view_row_z_reg};
    assign cam_ext   = {{CAM_W{1'b0}}, camera_position_reg};
    assign psc_ext   = {{PSC_W{1'b0}}, projection_scale_reg};
    assign rows[0]   = row_x_ext[ROW_W-1:0];
    assign rows[1]   = row_y_ext[ROW_W-1:0];
    assign rows[2]   = row_z_ext[ROW_W-1:0];
    assign cam       = cam_ext[CAM_W-1:0];
    assign psc       = psc_ext[PSC_W-1:0];
    assign tri_in    = s_axis_tdata[9*COORD_BITS-1:0];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    tcp_cull #(
        .COORD_BITS(COORD_BITS)
    ) u_cull (
        .clk    (clk),
        .en     (adv),
        .tri_in (tri_in),
        .cam    (cam),
        .front  (front)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_vtx
        tcp_view #(
            .COORD_BITS(COORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_view (
            .clk   (clk),
            .en    (adv),
            .rows  (rows),
            .point (tri_in[3*i+2 -: 3]),
            .view  (view[i])
        );

        tcp_screen #(
            .COORD_BITS(COORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_scr_x (
            .clk    (clk),
            .en     (adv),
            .scale  ($signed(psc[0])),
            .v      ($signed(view[i][0])),
            .w      ($signed(view[i][2])),
            .size   (screen_size_reg[SIZE_W-1:0]),
            .result (scr[2*i])
        );

        tcp_screen #(
            .COORD_BITS(COORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_scr_y (
            .clk    (clk),
            .en     (adv),
            .scale  ($signed(psc[1])),
            .v      ($signed(view[i][1])),
            .w      ($signed(view[i][2])),
            .size   (screen_size_reg[2*SIZE_W-1:SIZE_W]),
            .result (scr[2*i+1])
        );
    end

    // cull flag waits for the projection results
    always_ff @(posedge clk)
    begin
        if (adv)
            vis_reg <= {vis_reg[DLY-2:0], front};
    end

    assign out_data_next = vis_reg[DLY-1] ? OUT_W'(scr) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
            out_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_vis_reg  <= vis_reg[DLY-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_vis_reg;

endmodule

FILE: src/tcp_checker.sv
module tcp_checker
    import tcp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [0:0]       m_axis_tuser
);

    // a waiting beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // culled triangles carry zero coordinates
    a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("culled result with nonzero coordinates");

    // empty output register never blocks the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // input stalls only behind a stalled output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

endmodule

bind triangle_cull_and_project_unit tcp_checker u_tcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb
    import tcp_pkg::*;
();

    localparam int IN_W = 144;
    localparam int LAT = 26;

    typedef struct packed {
        logic        vis;
        logic [95:0] scr;
    } proj_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_VIEW_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    triangle_cull_and_project_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [63:0] row_x, row_y, row_z;
    logic [47:0] cam_pos;
    logic [31:0] proj_scale, scr_size;

    logic [IN_W-1:0] tri_pending[$];
    proj_t proj_expected[$];
    int mismatches = 0;
    int hold_off = 0;

    task automatic add_tri(logic [IN_W-1:0] t);
        tri_pending.insert(tri_pending.size(), t);
    endtask

    function automatic int idle_draw();
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic longint ent(logic [63:0] r, int i);
        return longint'(signed'(r[i*16 +: 16]));
    endfunction

    function automatic longint fdiv_floor(longint a);
        return a >>> 12;
    endfunction

    function automatic logic [15:0] to_screen(longint s, longint v, longint w, longint sz);
        longint num, den, q;
        if (w != 0)
        begin
            num = (s * v + w * 4096) * sz - w * 8192;
            den = w * 8192;
        end
        else
        begin
            num = (s * v + (longint'(1) << 24)) * sz - (longint'(1) << 25);
            den = longint'(1) << 25;
        end
        q = num / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic proj_t project_triangle(logic [IN_W-1:0] d);
        longint p[3][3];
        longint e1[3], e2[3], dv[3], n[3], dot, vx, vy, vz;
        proj_t r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i][j] = longint'(signed'(d[(i*3+j)*16 +: 16]));
        for (int j = 0; j < 3; j++)
        begin
            e1[j] = p[1][j] - p[0][j];
            e2[j] = p[2][j] - p[0][j];
            dv[j] = p[0][j] - ent({16'd0, cam_pos}, j);
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        dot = n[0] * dv[0] + n[1] * dv[1] + n[2] * dv[2];
        r = '0;
        if (dot >= 0)
            return r;
        r.vis = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            vx = fdiv_floor(ent(row_x, 0) * p[i][0] + ent(row_x, 1) * p[i][1]
                 + ent(row_x, 2) * p[i][2] + ent(row_x, 3) * 4096);
            vy = fdiv_floor(ent(row_y, 0) * p[i][0] + ent(row_y, 1) * p[i][1]
                 + ent(row_y, 2) * p[i][2] + ent(row_y, 3) * 4096);
            vz = fdiv_floor(ent(row_z, 0) * p[i][0] + ent(row_z, 1) * p[i][1]
                 + ent(row_z, 2) * p[i][2] + ent(row_z, 3) * 4096);
            r.scr[i*32 +: 16] = to_screen(ent(proj_scale, 0), vx, vz, scr_size[15:0]);
            r.scr[i*32+16 +: 16] = to_screen(ent(proj_scale, 1), vy, vz, scr_size[31:16]);
        end
        return r;
    endfunction

    task automatic report(string what, proj_t got, proj_t want);
        mismatches++;
        $display("%s: got vis=%0b scr=%h, want vis=%0b scr=%h", what,
                 got.vis, got.scr, want.vis, want.scr);
    endtask

    // handshakes as seen at the rising edge
    bit in_acc = 1'b0;
    bit out_acc = 1'b0;
    always @(posedge clk)
    begin
        in_acc  <= s_axis_tvalid && s_axis_tready;
        out_acc <= m_axis_tvalid && m_axis_tready;
    end

    // driver: one beat at a time with random gaps
    int gap_in = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_acc)
            begin
                proj_expected.insert(proj_expected.size(), project_triangle(s_axis_tdata));
                void'(tri_pending.pop_front());
                gap_in = idle_draw();
            end
            if (in_acc || !s_axis_tvalid)
            begin
                if (gap_in == 0 && tri_pending.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tri_pending[0];
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_in > 0)
                        gap_in = gap_in - 1;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(negedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // receiver
    int gap_out = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_acc)
                gap_out = idle_draw();
            if (hold_off > 0)
                m_axis_tready <= 1'b0;
            else if (gap_out > 0)
            begin
                m_axis_tready <= 1'b0;
                gap_out = gap_out - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        proj_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.vis = m_axis_tuser[0];
            got.scr = m_axis_tdata;
            if (proj_expected.size() == 0)
                report("unexpected beat", got, '0);
            else if (got !== proj_expected[0])
                report("result mismatch", got, proj_expected.pop_front());
            else
                void'(proj_expected.pop_front());
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_VIEW_X: row_x = val;
            REG_VIEW_Y: row_y = val;
            REG_VIEW_Z: row_z = val;
            REG_CAMERA: cam_pos = val[47:0];
            REG_SCALE:  proj_scale = val[31:0];
            REG_SCREEN: scr_size = val[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (tri_pending.size() > 0 || s_axis_tvalid || proj_expected.size() > 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_coord(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rnd_tri(int mode);
        logic [IN_W-1:0] t;
        for (int k = 0; k < 9; k++)
            t[k*16 +: 16] = rnd_coord(mode);
        return t;
    endfunction

    // one setup: identity-ish view with random content, or all random when wild
    task automatic rnd_setup(bit wild);
        logic [63:0] v[3];
        for (int r = 0; r < 3; r++)
        begin
            if (wild)
                v[r] = {$urandom(), $urandom()};
            else
            begin
                v[r] = '0;
                for (int c = 0; c < 3; c++)
                    v[r][c*16 +: 16] = (c == r) ? 16'(4096 + $urandom_range(0, 2047) - 1024)
                                                : 16'($urandom_range(0, 1023) - 512);
                v[r][48 +: 16] = (r == 2) ? 16'($urandom_range(8192, 24576))
                                          : 16'($urandom_range(0, 4095) - 2048);
            end
        end
        write_reg(REG_VIEW_X, v[0]);
        write_reg(REG_VIEW_Y, v[1]);
        write_reg(REG_VIEW_Z, v[2]);
        write_reg(REG_CAMERA, wild ? {$urandom(), $urandom()}
                                   : {16'($urandom_range(0, 4095) - 2048),
                                      16'($urandom_range(0, 4095) - 2048),
                                      16'($urandom_range(0, 4095) - 2048)});
        write_reg(REG_SCALE, wild ? $urandom() : {16'($urandom_range(2048, 8192)),
                                                  16'($urandom_range(2048, 8192))});
        write_reg(REG_SCREEN, wild ? $urandom() : {16'($urandom_range(1, 1080)),
                                                   16'($urandom_range(1, 1920))});
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        row_x = '0; row_y = '0; row_z = '0;
        cam_pos = '0; proj_scale = '0; scr_size = '0;

        // directed, all-zero registers first: zero screen size, zero w
        add_tri('0);
        add_tri({16'd0, 16'd0, 16'd4096, 16'd0, 16'd4096, 16'd0,
                 16'd4096, 16'd0, 16'd0});
        drain();
        write_reg(REG_VIEW_X, 64'h0000_0000_0000_1000);
        write_reg(REG_VIEW_Y, 64'h0000_0000_1000_0000);
        write_reg(REG_VIEW_Z, 64'h0000_0000_0000_0000);
        write_reg(REG_CAMERA, 48'h0000_0000_0000);
        write_reg(REG_SCALE, 32'h1000_1000);
        write_reg(REG_SCREEN, 32'd480 << 16 | 32'd640);
        // zero w with visible triangle, both windings, degenerate
        add_tri({16'hF000, 16'h0000, 16'h1000, 16'hF000, 16'h1000, 16'h0000,
                 16'hF000, 16'h0000, 16'h0000});
        add_tri({16'hF000, 16'h1000, 16'h0000, 16'hF000, 16'h0000, 16'h1000,
                 16'hF000, 16'h0000, 16'h0000});
        add_tri({16'h1000, 16'h1000, 16'h1000, 16'h0800, 16'h0800, 16'h0800,
                 16'h0000, 16'h0000, 16'h0000});
        add_tri({9{16'h7FFF}});
        add_tri({9{16'h8000}});
        add_tri({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                 16'h7FFF, 16'h7FFF, 16'h8000});
        add_tri({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h8000, 16'h8000, 16'h7FFF});
        drain();
        // extreme registers: saturation
        write_reg(REG_VIEW_X, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_VIEW_Y, 64'h8000_8000_8000_8000);
        write_reg(REG_VIEW_Z, 64'h0001_0000_0000_0001);
        write_reg(REG_CAMERA, 48'h7FFF_8000_7FFF);
        write_reg(REG_SCALE, 32'h8000_7FFF);
        write_reg(REG_SCREEN, 32'hFFFF_FFFF);
        for (int k = 0; k < 12; k++) add_tri(rnd_tri(0));
        drain();
        write_reg(REG_CAMERA, 48'h8000_7FFF_8000);
        write_reg(REG_VIEW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int k = 0; k < 8; k++) add_tri(rnd_tri(0));
        drain();

        // random phases; first one with a long receiver hold-off
        for (int ph = 0; ph < 10; ph++)
        begin
            rnd_setup(ph % 4 == 3);
            for (int k = 0; k < 75; k++)
                add_tri(rnd_tri($urandom_range(0, 2)));
            if (ph == 0)
            begin
                @(negedge clk);
                hold_off <= 300;
            end
            drain();
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Mismatches found");
        $finish;
    end
endmodule
